>>> src/htebp_pkg.sv
// Shared types and constants of the Huffman table encoder and bit packer.
package htebp_pkg;

    // Default configuration
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int ACC_W_DEF        = 7 + MAX_CODE_LEN_DEF;

    // Fixed field widths
    localparam int MODE_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int CODE_IN_W  = 32;
    localparam int LEN_IN_W   = 6;
    localparam int BYTE_W     = 8;
    localparam int BITS_W     = 4;
    localparam int TOTAL_W    = 32;
    localparam int CNT_W      = 4;
    localparam int PEND_W     = 7;
    localparam int PCNT_W     = 3;

    // Stream widths
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = MODE_W;
    localparam int M_TDATA_W  = 48;

    // Full output byte
    localparam logic [BITS_W-1:0] FULL_BYTE = BITS_W'(8);

    // Item kinds carried in the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } t_mode;

    // Result group handed from the packer stage to the byte emitter
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [BITS_W-1:0]  byte_bits;
        logic               last;
        logic               missing;
        logic [TOTAL_W-1:0] total;
    } t_emit_ctl;

endpackage

>>> src/htebp_emitter.sv
// Byte emitter: drains one packed result group as single output transactions.
module htebp_emitter #(
    parameter int DATA_W = htebp_pkg::ACC_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  htebp_pkg::t_emit_ctl             i_req_ctl,
    input  logic [DATA_W-1:0]                i_req_data,
    output logic                             o_free,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    // o_tdata: out_byte[7:0], byte_bits[11:8], total_bits[43:12], zero pad
    output logic [htebp_pkg::M_TDATA_W-1:0]  o_tdata,
    output logic                             o_tlast,
    // o_tuser: missing_code[0]
    output logic [0:0]                       o_tuser
);
    import htebp_pkg::*;

    localparam int NB_MAX = DATA_W / 8;
    localparam int PAD_W  = M_TDATA_W - BYTE_W - BITS_W - TOTAL_W;

    logic [CNT_W-1:0]   r_left;
    logic [DATA_W-1:0]  r_data;
    logic [BITS_W-1:0]  r_bits;
    logic               r_last;
    logic               r_miss;
    logic [TOTAL_W-1:0] r_total;

    logic               r_o_valid;
    logic [BYTE_W-1:0]  r_o_byte;
    logic [BITS_W-1:0]  r_o_bits;
    logic [TOTAL_W-1:0] r_o_total;
    logic               r_o_last;
    logic               r_o_miss;

    logic               pop;

    // Move one result into the output register when it is empty or being taken
    assign pop    = (r_left != '0) && (!r_o_valid || i_tready);
    assign o_free = (r_left == '0) || ((r_left == CNT_W'(1)) && pop);

    // Control: remaining results and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_req_valid) begin
                r_left <= i_req_ctl.count;
            end else if (pop) begin
                r_left <= r_left - CNT_W'(1);
            end
            if (pop) begin
                r_o_valid <= 1'b1;
            end else if (i_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload: load a new group, shift out one byte per pop
    always_ff @(posedge i_clk) begin
        if (i_req_valid) begin
            r_data  <= i_req_data;
            r_bits  <= i_req_ctl.byte_bits;
            r_last  <= i_req_ctl.last;
            r_miss  <= i_req_ctl.missing;
            r_total <= i_req_ctl.total;
        end else if (pop) begin
            r_data <= r_data >> 8;
        end
        if (pop) begin
            r_o_byte  <= r_data[BYTE_W-1:0];
            r_o_bits  <= r_bits;
            r_o_total <= r_total;
            r_o_last  <= r_last;
            r_o_miss  <= r_miss;
        end
    end

    assign o_tvalid   = r_o_valid;
    assign o_tdata    = {{PAD_W{1'b0}}, r_o_total, r_o_bits, r_o_byte};
    assign o_tlast    = r_o_last;
    assign o_tuser[0] = r_o_miss;

`ifndef NO_ASSERTIONS
    a_req_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid |-> o_free)
        else $error("emitter loaded while still busy");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CNT_W'(NB_MAX))
        else $error("emitter result count beyond accumulator bytes");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_miss) |-> (r_o_bits == '0 && r_o_byte == '0 && !r_o_last))
        else $error("missing-code result carries data");
`endif

endmodule

>>> src/huffman_table_encoder_bit_packer_top.sv
// Top level of the Huffman table encoder and LSB-first bit packer.
//
// After reset the block sweeps its code table once to mark every entry
// unloaded, one entry a cycle, with s_axis_tready low until the sweep ends.
// Items then enter at up to one per cycle while the emitter is free: a load
// writes the table entry in the cycle it is accepted, an encode reads its
// entry from the single-port-write, single-read table (registered read), and
// the packer stage appends the code to the pending bits. Results leave via a
// byte emitter, one output transaction per cycle while m_axis_tready is high,
// so an encode that completes k bytes (at most (7+MAX_CODE_LEN)/8) gives k
// transactions; the emitter's drain rate sets the sustained rate. A result is
// registered in turn in the packer stage, emitter group and output register.
module huffman_table_encoder_bit_packer_top #(
    parameter int MAX_CODE_LEN = htebp_pkg::MAX_CODE_LEN_DEF,
    parameter int SAMPLE_BITS  = htebp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // s_axis_tdata: sample[15:0], code_bits[47:16], code_length[53:48], zero pad
    input  logic [htebp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: mode[1:0]
    input  logic [htebp_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // m_axis_tdata: out_byte[7:0], byte_bits[11:8], total_bits[43:12], zero pad
    output logic [htebp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    // m_axis_tuser: missing_code[0]
    output logic [0:0]                       m_axis_tuser
);
    import htebp_pkg::*;

    localparam int CW     = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int ROW_W  = 1 + LEN_W + CW;
    localparam int DEPTH  = 2 ** SAMPLE_BITS;
    localparam int ACC_W  = PEND_W + MAX_CODE_LEN;
    localparam int HAVE_W = $clog2(ACC_W + 1);

    // Input fields
    logic [SAMPLE_W-1:0]   in_sample;
    logic [CODE_IN_W-1:0]  in_code;
    logic [LEN_IN_W-1:0]   in_len;
    t_mode                 in_mode;

    assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
    assign in_code   = s_axis_tdata[SAMPLE_W +: CODE_IN_W];
    assign in_len    = s_axis_tdata[SAMPLE_W + CODE_IN_W +: LEN_IN_W];
    assign in_mode   = t_mode'(s_axis_tuser);

    // Code table: {valid, length, code}
    logic [ROW_W-1:0]       mem [DEPTH];
    logic [ROW_W-1:0]       r_rd_data;
    logic                   mem_we;
    logic [SAMPLE_BITS-1:0] mem_waddr;
    logic [ROW_W-1:0]       mem_wdata;
    logic                   rd_en;

    // Clearing sweep
    logic                   r_clr_active;
    logic [SAMPLE_BITS-1:0] r_clr_addr;

    // Packer stage and bit accumulator state
    logic                   r_a_valid;
    logic                   r_a_flush;
    logic [PEND_W-1:0]      r_pend_bits;
    logic [PCNT_W-1:0]      r_pend_count;
    logic [TOTAL_W-1:0]     r_bit_total;

    logic                   accept;
    logic                   a_go;
    logic                   emit_free;

    // Load path
    logic [LEN_IN_W-1:0]    len_sat;
    logic [CODE_IN_W-1:0]   code_mask;
    logic [CODE_IN_W-1:0]   code_masked;

    // Packer stage datapath
    logic                   rd_valid;
    logic [LEN_W-1:0]       rd_len;
    logic [CW-1:0]          rd_code;
    logic [ACC_W-1:0]       acc;
    logic [HAVE_W-1:0]      have;
    logic [HAVE_W-4:0]      nbytes;
    logic [ACC_W-1:0]       acc_rest;
    logic [TOTAL_W-1:0]     total_next;

    logic                   req_valid;
    t_emit_ctl              req_ctl;
    logic [ACC_W-1:0]       req_data;

    // Handshake
    assign a_go          = r_a_valid && emit_free;
    assign s_axis_tready = !r_clr_active && (!r_a_valid || a_go);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rd_en         = accept && (in_mode == MODE_ENCODE);

    // Saturate and mask the code for a load
    always_comb begin
        len_sat = (in_len > LEN_IN_W'(MAX_CODE_LEN)) ? LEN_IN_W'(MAX_CODE_LEN) : in_len;
        for (int i = 0; i < CODE_IN_W; i++) begin
            code_mask[i] = (i < int'(len_sat));
        end
        code_masked = in_code & code_mask;
    end

    // Select table write: clearing sweep or load
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        if (r_clr_active) begin
            mem_we = 1'b1;
        end else if (accept && (in_mode == MODE_LOAD)) begin
            mem_we    = 1'b1;
            mem_waddr = in_sample[SAMPLE_BITS-1:0];
            mem_wdata = {1'b1, len_sat[LEN_W-1:0], code_masked[CW-1:0]};
        end
    end

    // Table storage with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[in_sample[SAMPLE_BITS-1:0]];
        end
    end

    // Sweep the table once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + SAMPLE_BITS'(1);
            if (r_clr_addr == {SAMPLE_BITS{1'b1}}) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Advance encode and flush items into the packer stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= (in_mode == MODE_ENCODE) || (in_mode == MODE_FLUSH);
        end else if (a_go) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_flush <= (in_mode == MODE_FLUSH);
        end
    end

    // Append the code to the pending bits
    assign rd_valid = r_rd_data[ROW_W-1];
    assign rd_len   = r_rd_data[CW +: LEN_W];
    assign rd_code  = r_rd_data[CW-1:0];

    always_comb begin
        acc        = ACC_W'(r_pend_bits) | (ACC_W'(rd_code) << r_pend_count);
        have       = HAVE_W'(r_pend_count) + HAVE_W'(rd_len);
        nbytes     = have[HAVE_W-1:3];
        acc_rest   = acc >> {nbytes, 3'b000};
        total_next = r_bit_total + TOTAL_W'(rd_len);
    end

    // Build the result group for the emitter
    always_comb begin
        req_valid         = 1'b0;
        req_ctl.count     = '0;
        req_ctl.byte_bits = '0;
        req_ctl.last      = 1'b0;
        req_ctl.missing   = 1'b0;
        req_ctl.total     = r_bit_total;
        req_data          = '0;
        if (a_go) begin
            if (r_a_flush) begin
                req_valid         = 1'b1;
                req_ctl.count     = CNT_W'(1);
                req_ctl.byte_bits = BITS_W'(r_pend_count);
                req_ctl.last      = 1'b1;
                req_data          = ACC_W'(r_pend_bits);
            end else if (!rd_valid) begin
                req_valid       = 1'b1;
                req_ctl.count   = CNT_W'(1);
                req_ctl.missing = 1'b1;
            end else if (nbytes != '0) begin
                req_valid         = 1'b1;
                req_ctl.count     = CNT_W'(nbytes);
                req_ctl.byte_bits = FULL_BYTE;
                req_ctl.total     = total_next;
                req_data          = acc;
            end
        end
    end

    // Update pending bits and the running bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits  <= '0;
            r_pend_count <= '0;
            r_bit_total  <= '0;
        end else if (a_go) begin
            if (r_a_flush) begin
                r_pend_bits  <= '0;
                r_pend_count <= '0;
                r_bit_total  <= '0;
            end else if (rd_valid && (rd_len != '0)) begin
                r_pend_bits  <= acc_rest[PEND_W-1:0];
                r_pend_count <= have[PCNT_W-1:0];
                r_bit_total  <= total_next;
            end
        end
    end

    htebp_emitter #(
        .DATA_W (ACC_W)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req_ctl   (req_ctl),
        .i_req_data  (req_data),
        .o_free      (emit_free),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast),
        .o_tuser     (m_axis_tuser)
    );

`ifndef NO_ASSERTIONS
    a_clr_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !s_axis_tready)
        else $error("input taken during table sweep");

    a_flush_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && r_a_flush) |=> (r_pend_count == '0 && r_bit_total == '0))
        else $error("flush did not restart the stream");

    a_total_adds_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && !r_a_flush && rd_valid && rd_len != '0)
        |=> (r_bit_total == $past(r_bit_total) + TOTAL_W'($past(rd_len))))
        else $error("bit count not advanced by code length");
`endif

endmodule

>>> tb/tb_huffman_table_encoder_bit_packer_top.sv
// Self-checking testbench for the Huffman table encoder and LSB-first bit packer.
module tb_huffman_table_encoder_bit_packer_top;
    import htebp_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;
    localparam int CODE_LIMIT  = MAX_CODE_LEN_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 32;
    localparam int RANDOM_ITEMS = 344;
    localparam int QUIET_ITEMS  = 80;

    // One output transaction as the checker sees it
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [BITS_W-1:0]  byte_bits;
        logic [TOTAL_W-1:0] total_bits;
        logic               is_last;
        logic               missing_code;
    } t_packed_byte;

    // Bit packer predictor and the queue of bytes it expects
    class packer_scoreboard;
        logic [CODE_IN_W-1:0] code_word [logic [SAMPLE_W-1:0]];
        logic [LEN_IN_W-1:0]  code_len [logic [SAMPLE_W-1:0]];
        logic [PEND_W-1:0]    pend_bits;
        logic [PCNT_W-1:0]    pend_count;
        logic [TOTAL_W-1:0]   bit_total;
        t_packed_byte         expected_bytes[$];
        int                   errors;

        function new();
            pend_bits  = '0;
            pend_count = '0;
            bit_total  = '0;
            errors     = 0;
        endfunction

        function string show(t_packed_byte r);
            return $sformatf("byte=%h bits=%0d total=%0d last=%b missing=%b",
                             r.out_byte, r.byte_bits, r.total_bits, r.is_last,
                             r.missing_code);
        endfunction

        // Predict the bytes caused by one accepted input transaction
        function void note_item(logic [MODE_W-1:0] mode, logic [SAMPLE_W-1:0] sample,
                                logic [CODE_IN_W-1:0] code, logic [LEN_IN_W-1:0] len);
            logic [CODE_IN_W:0]         mask;
            logic [PEND_W+CODE_IN_W-1:0] acc;
            int                          have;
            t_packed_byte                r;
            case (mode)
                MODE_LOAD: begin
                    // Saturate the length and drop code bits above it
                    if (len > CODE_LIMIT)
                        len = LEN_IN_W'(CODE_LIMIT);
                    mask = (33'd1 << len) - 33'd1;
                    code_word[sample] = code & mask[CODE_IN_W-1:0];
                    code_len[sample]  = len;
                end
                MODE_ENCODE: begin
                    if (!code_len.exists(sample)) begin
                        r = '{out_byte: '0, byte_bits: '0, total_bits: bit_total,
                              is_last: 1'b0, missing_code: 1'b1};
                        expected_bytes.push_back(r);
                    end else if (code_len[sample] != 0) begin
                        // Append the code above the pending bits, emit full bytes
                        acc = (PEND_W+CODE_IN_W)'(pend_bits)
                            | ((PEND_W+CODE_IN_W)'(code_word[sample]) << pend_count);
                        have = pend_count + code_len[sample];
                        bit_total += code_len[sample];
                        while (have >= 8) begin
                            r = '{out_byte: acc[7:0], byte_bits: FULL_BYTE,
                                  total_bits: bit_total, is_last: 1'b0,
                                  missing_code: 1'b0};
                            expected_bytes.push_back(r);
                            acc  = acc >> 8;
                            have -= 8;
                        end
                        pend_bits  = acc[PEND_W-1:0];
                        pend_count = PCNT_W'(have);
                    end
                end
                MODE_FLUSH: begin
                    r = '{out_byte: BYTE_W'(pend_bits), byte_bits: BITS_W'(pend_count),
                          total_bits: bit_total, is_last: 1'b1, missing_code: 1'b0};
                    expected_bytes.push_back(r);
                    pend_bits  = '0;
                    pend_count = '0;
                    bit_total  = '0;
                end
                default: ;
            endcase
        endfunction

        // Compare one output transaction with the oldest expected byte
        function void check_byte(t_packed_byte got);
            t_packed_byte want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual %s",
                         $time, show(got));
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_bits !== want.byte_bits
                    || got.total_bits !== want.total_bits || got.is_last !== want.is_last
                    || got.missing_code !== want.missing_code) begin
                $display("%0t: output mismatch, expected %s, actual %s",
                         $time, show(want), show(got));
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [S_TUSER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;

    packer_scoreboard      board;
    bit                    quiet = 1'b0;
    int                    sink_stall = 0;
    int                    cycle_count = 0;
    logic [SAMPLE_W-1:0]   sample_pool [POOL_SIZE];

    huffman_table_encoder_bit_packer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Check each output transaction and throttle the sink in random bursts
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_byte('{out_byte: m_axis_tdata[7:0], byte_bits: m_axis_tdata[11:8],
                               total_bits: m_axis_tdata[43:12], is_last: m_axis_tlast,
                               missing_code: m_axis_tuser[0]});
        if (sink_stall > 0) begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sink_stall    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Present one item, hold it until accepted, then maybe pause the source
    task automatic send_item(logic [MODE_W-1:0] mode, logic [SAMPLE_W-1:0] sample,
                             logic [CODE_IN_W-1:0] code, logic [LEN_IN_W-1:0] len);
        s_axis_tdata  <= {2'b00, len, code, sample};
        s_axis_tuser  <= mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(mode, sample, code, len);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Mostly short codes, sometimes empty, full or oversized lengths
    function automatic logic [LEN_IN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return LEN_IN_W'(CODE_LIMIT);
        else if (r == 2)
            return LEN_IN_W'($urandom_range(CODE_LIMIT + 1, 63));
        else if (r < 7)
            return LEN_IN_W'($urandom_range(13, CODE_LIMIT - 1));
        return LEN_IN_W'($urandom_range(1, 12));
    endfunction

    // Random mix weighted toward encodes of loaded samples
    task automatic send_random_item();
        int                  r;
        logic [SAMPLE_W-1:0] sample;
        r = $urandom_range(0, 99);
        sample = ($urandom_range(0, 99) < 90) ? sample_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : SAMPLE_W'($urandom);
        if (r < 15)
            send_item(MODE_LOAD, sample, $urandom, pick_length());
        else if (r < 88)
            send_item(MODE_ENCODE, sample, $urandom, LEN_IN_W'($urandom));
        else if (r < 96)
            send_item(MODE_FLUSH, sample, $urandom, LEN_IN_W'($urandom));
        else
            send_item(MODE_UNKNOWN, sample, $urandom, LEN_IN_W'($urandom));
    endtask

    initial begin
        board = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: unloaded sample, empty flush, extreme loads and packing
        send_item(MODE_ENCODE, 16'd5, '0, '0);
        send_item(MODE_FLUSH, '0, '0, '0);
        send_item(MODE_LOAD, 16'h8000, 32'hFFFF_FFFF, 6'd32);
        send_item(MODE_LOAD, 16'h7FFF, 32'hDEAD_BEEF, 6'd63);
        send_item(MODE_LOAD, 16'hFFFF, 32'h0000_0005, 6'd3);
        send_item(MODE_LOAD, 16'h0000, 32'hFFFF_FFFF, 6'd0);
        send_item(MODE_LOAD, 16'h0001, 32'hFFFF_FFF3, 6'd5);
        send_item(MODE_LOAD, 16'h0002, 32'h0000_0000, 6'd7);
        send_item(MODE_ENCODE, 16'h0000, '0, '0);
        send_item(MODE_ENCODE, 16'hFFFF, '0, '0);
        send_item(MODE_ENCODE, 16'h8000, '0, '0);
        send_item(MODE_ENCODE, 16'h7FFF, '0, '0);
        send_item(MODE_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
        send_item(MODE_ENCODE, 16'h0001, '0, '0);
        send_item(MODE_FLUSH, '0, '0, '0);
        send_item(MODE_ENCODE, 16'h0002, '0, '0);
        send_item(MODE_ENCODE, 16'h8000, '0, '0);
        send_item(MODE_ENCODE, 16'hFFFF, '0, '0);
        send_item(MODE_FLUSH, '0, '0, '0);
        send_item(MODE_ENCODE, 16'd100, '0, '0);
        send_item(MODE_LOAD, 16'hFFFF, 32'h0000_0000, 6'd1);
        send_item(MODE_ENCODE, 16'hFFFF, '0, '0);
        send_item(MODE_FLUSH, '0, '0, '0);

        // Load a pool of samples so most random encodes hit a code
        foreach (sample_pool[i])
            sample_pool[i] = SAMPLE_W'($urandom);
        sample_pool[0] = 16'hFFFF;
        sample_pool[1] = 16'h8000;
        sample_pool[2] = 16'h7FFF;
        sample_pool[3] = 16'h0000;
        foreach (sample_pool[i])
            send_item(MODE_LOAD, sample_pool[i], $urandom, pick_length());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_random_item();
        end
        send_item(MODE_FLUSH, '0, '0, '0);
        s_axis_tvalid <= 1'b0;

        // Drain, then watch for stray output
        while (board.expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
